FILE: design/swd_pkg.sv
package swd_pkg;

  localparam int unsigned RESET_HIGH_CLOCKS_DEF = 64;
  localparam int unsigned RESET_LOW_CLOCKS      = 4;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Command codes carried in the opcode field.
  localparam logic [1:0] OP_IDLE       = 2'd0;
  localparam logic [1:0] OP_START      = 2'd1;
  localparam logic [1:0] OP_LINE_RESET = 2'd2;

  // ACK patterns as received, LSB first.
  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  // Completion status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_FAULT    = 3'd2;
  localparam logic [2:0] ST_PROTOCOL = 3'd3;
  localparam logic [2:0] ST_PARITY   = 3'd4;

  // Fixed bits of the request header: start, stop and park.
  localparam logic [7:0] HDR_FIXED = 8'h81;

endpackage

FILE: design/swd_host_transfer_engine.sv
// Serial Wire Debug host transfer engine. Every input transfer stands for one
// SWCLK period and carries the SWDIO level sampled in it; every input transfer
// produces exactly one output transfer giving the level to drive, the drive
// enable, busy, status and, on the last period of a good read, the received
// word (tlast marks the last period of a transfer or a line reset). A start
// opcode on an idle engine begins a request in that same period; a line-reset
// opcode drives RESET_HIGH_CLOCKS high periods followed by four low ones.
// Opcodes are ignored while busy. The engine takes one input transfer per
// clock cycle and registers each result in the output register on
// acceptance; the only stall comes from out_tready back-pressure.
module swd_host_transfer_engine #(
  parameter int unsigned RESET_HIGH_CLOCKS = swd_pkg::RESET_HIGH_CLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode[1:0], ap_select[2], read_request[3], reg_addr[5:4],
  // write_data[37:6], swdio_in[38], zero fill[39]
  input  logic [swd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // swdio_out[0], swdio_drive[1], busy_res[2], status[5:3],
  // read_data[37:6], zero fill[39:38]
  output logic [swd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR,
    PH_TRN1,
    PH_ACK,
    PH_RDATA,
    PH_TRNEND,
    PH_TRNW,
    PH_WDATA,
    PH_RSTHI,
    PH_RSTLO
  } phase_t;

  localparam logic [6:0] RST_HI_CNT = 7'(RESET_HIGH_CLOCKS);
  localparam logic [6:0] RST_LO_CNT = 7'(swd_pkg::RESET_LOW_CLOCKS);

  phase_t      phase_r, phase_nxt;
  logic [6:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [31:0] data_r, data_nxt;
  logic        parity_r, parity_nxt;
  logic [2:0]  ack_r, ack_nxt;
  logic        is_read_r, is_read_nxt;

  logic        out_valid_r;
  logic        swdio_out_r, swdio_out_nxt;
  logic        swdio_drive_r, swdio_drive_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] read_data_r, read_data_nxt;

  logic [1:0]  opcode;
  logic        ap_select;
  logic        read_request;
  logic [1:0]  reg_addr;
  logic [31:0] write_data;
  logic        swdio_in;
  logic        accept;
  logic [6:0]  count_inc;

  assign opcode       = in_tdata[1:0];
  assign ap_select    = in_tdata[2];
  assign read_request = in_tdata[3];
  assign reg_addr     = in_tdata[5:4];
  assign write_data   = in_tdata[37:6];
  assign swdio_in     = in_tdata[38];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    header_nxt      = header_r;
    data_nxt        = data_r;
    parity_nxt      = parity_r;
    ack_nxt         = ack_r;
    is_read_nxt     = is_read_r;
    swdio_out_nxt   = 1'b0;
    swdio_drive_nxt = 1'b1;
    busy_nxt        = 1'b0;
    done_nxt        = 1'b0;
    status_nxt      = swd_pkg::ST_OK;
    read_data_nxt   = '0;

    // An idle engine starts the new request in this same period.
    if (phase_r == PH_IDLE) begin
      if (opcode == swd_pkg::OP_START) begin
        header_nxt = swd_pkg::HDR_FIXED
                   | {2'b00, ^{ap_select, read_request, reg_addr}, reg_addr[1],
                      reg_addr[0], read_request, ap_select, 1'b0};
        is_read_nxt   = read_request;
        data_nxt      = write_data;
        parity_nxt    = 1'b0;
        ack_nxt       = '0;
        bit_count_nxt = '0;
        phase_nxt     = PH_HDR;
      end else if (opcode == swd_pkg::OP_LINE_RESET) begin
        bit_count_nxt = '0;
        phase_nxt     = PH_RSTHI;
      end
    end

    count_inc = bit_count_nxt + 7'd1;

    case (phase_nxt)
      PH_HDR: begin
        busy_nxt      = 1'b1;
        swdio_out_nxt = header_nxt[bit_count_nxt[2:0]];
        if (bit_count_nxt == 7'd7) begin
          bit_count_nxt = '0;
          phase_nxt     = PH_TRN1;
        end else begin
          bit_count_nxt = count_inc;
        end
      end
      PH_TRN1: begin
        busy_nxt        = 1'b1;
        swdio_drive_nxt = 1'b0;
        bit_count_nxt   = '0;
        phase_nxt       = PH_ACK;
      end
      PH_ACK: begin
        busy_nxt        = 1'b1;
        swdio_drive_nxt = 1'b0;
        ack_nxt         = ack_nxt | ({2'b00, swdio_in} << bit_count_nxt[1:0]);
        if (bit_count_nxt == 7'd2) begin
          bit_count_nxt = '0;
          if (ack_nxt == swd_pkg::ACK_OK) begin
            if (is_read_nxt) begin
              data_nxt   = '0;
              parity_nxt = 1'b0;
              phase_nxt  = PH_RDATA;
            end else begin
              phase_nxt = PH_TRNW;
            end
          end else if (ack_nxt == swd_pkg::ACK_WAIT) begin
            done_nxt   = 1'b1;
            status_nxt = swd_pkg::ST_WAIT;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_TRNEND;
          end
        end else begin
          bit_count_nxt = count_inc;
        end
      end
      PH_RDATA: begin
        busy_nxt        = 1'b1;
        swdio_drive_nxt = 1'b0;
        // Data arrives LSB first, so shifting in from the top leaves the
        // word in order after 32 periods.
        if (!bit_count_nxt[5]) begin
          data_nxt      = {swdio_in, data_nxt[31:1]};
          parity_nxt    = parity_nxt ^ swdio_in;
          bit_count_nxt = count_inc;
        end else if (swdio_in != parity_nxt) begin
          done_nxt   = 1'b1;
          status_nxt = swd_pkg::ST_PARITY;
          phase_nxt  = PH_IDLE;
        end else begin
          phase_nxt = PH_TRNEND;
        end
      end
      PH_TRNEND: begin
        busy_nxt        = 1'b1;
        swdio_drive_nxt = 1'b0;
        done_nxt        = 1'b1;
        if (ack_nxt == swd_pkg::ACK_OK) begin
          status_nxt    = swd_pkg::ST_OK;
          read_data_nxt = data_nxt;
        end else if (ack_nxt == swd_pkg::ACK_FAULT) begin
          status_nxt = swd_pkg::ST_FAULT;
        end else begin
          status_nxt = swd_pkg::ST_PROTOCOL;
        end
        phase_nxt = PH_IDLE;
      end
      PH_TRNW: begin
        busy_nxt        = 1'b1;
        swdio_drive_nxt = 1'b0;
        bit_count_nxt   = '0;
        parity_nxt      = 1'b0;
        phase_nxt       = PH_WDATA;
      end
      PH_WDATA: begin
        busy_nxt = 1'b1;
        if (!bit_count_nxt[5]) begin
          swdio_out_nxt = data_nxt[0];
          parity_nxt    = parity_nxt ^ data_nxt[0];
          data_nxt      = {1'b0, data_nxt[31:1]};
          bit_count_nxt = count_inc;
        end else begin
          swdio_out_nxt = parity_nxt;
          done_nxt      = 1'b1;
          phase_nxt     = PH_IDLE;
        end
      end
      PH_RSTHI: begin
        busy_nxt      = 1'b1;
        swdio_out_nxt = 1'b1;
        if (count_inc >= RST_HI_CNT || count_inc == 7'd0) begin
          bit_count_nxt = '0;
          phase_nxt     = PH_RSTLO;
        end else begin
          bit_count_nxt = count_inc;
        end
      end
      PH_RSTLO: begin
        busy_nxt = 1'b1;
        if (count_inc >= RST_LO_CNT) begin
          bit_count_nxt = '0;
          done_nxt      = 1'b1;
          phase_nxt     = PH_IDLE;
        end else begin
          bit_count_nxt = count_inc;
        end
      end
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        bit_count_r   <= bit_count_nxt;
        header_r      <= header_nxt;
        data_r        <= data_nxt;
        parity_r      <= parity_nxt;
        ack_r         <= ack_nxt;
        is_read_r     <= is_read_nxt;
        swdio_out_r   <= swdio_out_nxt;
        swdio_drive_r <= swdio_drive_nxt;
        busy_r        <= busy_nxt;
        done_r        <= done_nxt;
        status_r      <= status_nxt;
        read_data_r   <= read_data_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {2'b00, read_data_r, status_r, busy_r, swdio_drive_r, swdio_out_r};

  // A released line always reports a low output level.
  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !swdio_drive_r |-> !swdio_out_r)
    else $error("SWDIO released with a nonzero output level");

  // Status and read data only appear in the closing period.
  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != swd_pkg::ST_OK || read_data_r != '0) |-> done_r)
    else $error("status or read data outside the closing period");

  // The closing period always belongs to a busy stretch.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> busy_r)
    else $error("done reported on an idle period");

  // A finished period returns the engine to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_nxt |=> phase_r == PH_IDLE)
    else $error("engine still active after its closing period");

  // With nothing held in the output register the input is never stalled.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty output register");

endmodule
